[hdl/assert_macros.svh]
// Assertion macros shared by the checker files of the keyboard decoder.
// Needs nothing else; each macro checks a clocked property with reset masking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyboard decoder check failed");

// Check a consequence in the cycle after its cause
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyboard decoder check failed");

`endif

[hdl/ps2kbd_pkg.sv]
// Types, scan code constants and key map tables for the PS/2 keyboard decoder.
// Used by ps2kbd_keymap and the decoder top level; depends on nothing.
package ps2kbd_pkg;

  // Prefix and special scan codes (set 2)
  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [7:0] PREFIX_REL = 8'hF0;
  localparam logic [7:0] SC_CAPS    = 8'h58;
  localparam logic [7:0] SC_NUM     = 8'h77;
  localparam logic [7:0] SC_SCROLL  = 8'h7E;
  localparam logic [7:0] SC_LSHIFT  = 8'h12;
  localparam logic [7:0] SC_RSHIFT  = 8'h59;
  localparam logic [7:0] SC_CTRL    = 8'h14;
  localparam logic [7:0] SC_ALT     = 8'h11;
  localparam logic [7:0] SC_LWIN    = 8'h1F;
  localparam logic [7:0] SC_RWIN    = 8'h27;
  localparam logic [7:0] SC_MENU    = 8'h2F;

  // Key zones
  localparam logic [1:0] ZONE_MAIN = 2'd0;
  localparam logic [1:0] ZONE_MODS = 2'd1;
  localparam logic [1:0] ZONE_PAD  = 2'd2;
  localparam logic [1:0] ZONE_NAV  = 2'd3;

  // ASCII offsets for letter handling
  localparam logic [6:0] CTRL_OFFSET  = 7'h60;
  localparam logic [6:0] UPPER_OFFSET = 7'h20;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_FIXED,
    KIND_SHIFT,
    KIND_LETTER,
    KIND_NUM
  } key_kind_t;

  typedef struct packed {
    logic       mapped;
    logic [1:0] zone;
    logic [2:0] row;
    logic [3:0] col;
    key_kind_t  kind;
    logic [6:0] lo;
    logic [6:0] hi;
  } keydef_t;

  // Modifier and lock state that shapes the character
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic caps;
    logic num;
  } key_mod_t;

  function automatic keydef_t mk(logic [1:0] zone, logic [2:0] row, logic [3:0] col,
                                 key_kind_t kind, logic [6:0] lo, logic [6:0] hi);
    keydef_t d;
    d.mapped = 1'b1;
    d.zone   = zone;
    d.row    = row;
    d.col    = col;
    d.kind   = kind;
    d.lo     = lo;
    d.hi     = hi;
    return d;
  endfunction

  // Key map for codes without the extended prefix
  function automatic keydef_t main_key(logic [7:0] code);
    keydef_t d;
    d = '0;
    case (code)
      8'h0E: d = mk(ZONE_MAIN, 3'd0, 4'd0,  KIND_SHIFT,  7'h60, 7'h7E); // ` ~
      8'h16: d = mk(ZONE_MAIN, 3'd0, 4'd1,  KIND_SHIFT,  7'h31, 7'h21); // 1 !
      8'h1E: d = mk(ZONE_MAIN, 3'd0, 4'd2,  KIND_SHIFT,  7'h32, 7'h40); // 2 @
      8'h26: d = mk(ZONE_MAIN, 3'd0, 4'd3,  KIND_SHIFT,  7'h33, 7'h23); // 3 #
      8'h25: d = mk(ZONE_MAIN, 3'd0, 4'd4,  KIND_SHIFT,  7'h34, 7'h24); // 4 $
      8'h2E: d = mk(ZONE_MAIN, 3'd0, 4'd5,  KIND_SHIFT,  7'h35, 7'h25); // 5 %
      8'h36: d = mk(ZONE_MAIN, 3'd0, 4'd6,  KIND_SHIFT,  7'h36, 7'h5E); // 6 ^
      8'h3D: d = mk(ZONE_MAIN, 3'd0, 4'd7,  KIND_SHIFT,  7'h37, 7'h26); // 7 &
      8'h3E: d = mk(ZONE_MAIN, 3'd0, 4'd8,  KIND_SHIFT,  7'h38, 7'h2A); // 8 *
      8'h46: d = mk(ZONE_MAIN, 3'd0, 4'd9,  KIND_SHIFT,  7'h39, 7'h28); // 9 (
      8'h45: d = mk(ZONE_MAIN, 3'd0, 4'd10, KIND_SHIFT,  7'h30, 7'h29); // 0 )
      8'h4E: d = mk(ZONE_MAIN, 3'd0, 4'd11, KIND_SHIFT,  7'h2D, 7'h5F); // - _
      8'h55: d = mk(ZONE_MAIN, 3'd0, 4'd12, KIND_SHIFT,  7'h3D, 7'h2B); // = +
      8'h66: d = mk(ZONE_MAIN, 3'd0, 4'd13, KIND_FIXED,  7'h08, 7'h00); // backspace
      8'h0D: d = mk(ZONE_MAIN, 3'd1, 4'd0,  KIND_FIXED,  7'h09, 7'h00); // tab
      8'h15: d = mk(ZONE_MAIN, 3'd1, 4'd1,  KIND_LETTER, 7'h71, 7'h00); // q
      8'h1D: d = mk(ZONE_MAIN, 3'd1, 4'd2,  KIND_LETTER, 7'h77, 7'h00); // w
      8'h24: d = mk(ZONE_MAIN, 3'd1, 4'd3,  KIND_LETTER, 7'h65, 7'h00); // e
      8'h2D: d = mk(ZONE_MAIN, 3'd1, 4'd4,  KIND_LETTER, 7'h72, 7'h00); // r
      8'h2C: d = mk(ZONE_MAIN, 3'd1, 4'd5,  KIND_LETTER, 7'h74, 7'h00); // t
      8'h35: d = mk(ZONE_MAIN, 3'd1, 4'd6,  KIND_LETTER, 7'h79, 7'h00); // y
      8'h3C: d = mk(ZONE_MAIN, 3'd1, 4'd7,  KIND_LETTER, 7'h75, 7'h00); // u
      8'h43: d = mk(ZONE_MAIN, 3'd1, 4'd8,  KIND_LETTER, 7'h69, 7'h00); // i
      8'h44: d = mk(ZONE_MAIN, 3'd1, 4'd9,  KIND_LETTER, 7'h6F, 7'h00); // o
      8'h4D: d = mk(ZONE_MAIN, 3'd1, 4'd10, KIND_LETTER, 7'h70, 7'h00); // p
      8'h54: d = mk(ZONE_MAIN, 3'd1, 4'd11, KIND_SHIFT,  7'h5B, 7'h7B); // [ {
      8'h5B: d = mk(ZONE_MAIN, 3'd1, 4'd12, KIND_SHIFT,  7'h5D, 7'h7D); // ] }
      8'h5D: d = mk(ZONE_MAIN, 3'd1, 4'd13, KIND_SHIFT,  7'h5C, 7'h7C); // \ |
      8'h58: d = mk(ZONE_MODS, 3'd2, 4'd0,  KIND_NONE,   7'h00, 7'h00); // caps lock
      8'h1C: d = mk(ZONE_MAIN, 3'd2, 4'd1,  KIND_LETTER, 7'h61, 7'h00); // a
      8'h1B: d = mk(ZONE_MAIN, 3'd2, 4'd2,  KIND_LETTER, 7'h73, 7'h00); // s
      8'h23: d = mk(ZONE_MAIN, 3'd2, 4'd3,  KIND_LETTER, 7'h64, 7'h00); // d
      8'h2B: d = mk(ZONE_MAIN, 3'd2, 4'd4,  KIND_LETTER, 7'h66, 7'h00); // f
      8'h34: d = mk(ZONE_MAIN, 3'd2, 4'd5,  KIND_LETTER, 7'h67, 7'h00); // g
      8'h33: d = mk(ZONE_MAIN, 3'd2, 4'd6,  KIND_LETTER, 7'h68, 7'h00); // h
      8'h3B: d = mk(ZONE_MAIN, 3'd2, 4'd7,  KIND_LETTER, 7'h6A, 7'h00); // j
      8'h42: d = mk(ZONE_MAIN, 3'd2, 4'd8,  KIND_LETTER, 7'h6B, 7'h00); // k
      8'h4B: d = mk(ZONE_MAIN, 3'd2, 4'd9,  KIND_LETTER, 7'h6C, 7'h00); // l
      8'h4C: d = mk(ZONE_MAIN, 3'd2, 4'd10, KIND_SHIFT,  7'h3B, 7'h3A); // ; :
      8'h52: d = mk(ZONE_MAIN, 3'd2, 4'd11, KIND_SHIFT,  7'h27, 7'h22); // ' "
      8'h5A: d = mk(ZONE_MAIN, 3'd2, 4'd12, KIND_FIXED,  7'h0D, 7'h00); // enter
      8'h12: d = mk(ZONE_MODS, 3'd3, 4'd0,  KIND_NONE,   7'h00, 7'h00); // left shift
      8'h1A: d = mk(ZONE_MAIN, 3'd3, 4'd1,  KIND_LETTER, 7'h7A, 7'h00); // z
      8'h22: d = mk(ZONE_MAIN, 3'd3, 4'd2,  KIND_LETTER, 7'h78, 7'h00); // x
      8'h21: d = mk(ZONE_MAIN, 3'd3, 4'd3,  KIND_LETTER, 7'h63, 7'h00); // c
      8'h2A: d = mk(ZONE_MAIN, 3'd3, 4'd4,  KIND_LETTER, 7'h76, 7'h00); // v
      8'h32: d = mk(ZONE_MAIN, 3'd3, 4'd5,  KIND_LETTER, 7'h62, 7'h00); // b
      8'h31: d = mk(ZONE_MAIN, 3'd3, 4'd6,  KIND_LETTER, 7'h6E, 7'h00); // n
      8'h3A: d = mk(ZONE_MAIN, 3'd3, 4'd7,  KIND_LETTER, 7'h6D, 7'h00); // m
      8'h41: d = mk(ZONE_MAIN, 3'd3, 4'd8,  KIND_SHIFT,  7'h2C, 7'h3C); // , <
      8'h49: d = mk(ZONE_MAIN, 3'd3, 4'd9,  KIND_SHIFT,  7'h2E, 7'h3E); // . >
      8'h4A: d = mk(ZONE_MAIN, 3'd3, 4'd10, KIND_SHIFT,  7'h2F, 7'h3F); // / ?
      8'h59: d = mk(ZONE_MODS, 3'd3, 4'd11, KIND_NONE,   7'h00, 7'h00); // right shift
      8'h14: d = mk(ZONE_MODS, 3'd4, 4'd0,  KIND_NONE,   7'h00, 7'h00); // left ctrl
      8'h11: d = mk(ZONE_MODS, 3'd4, 4'd2,  KIND_NONE,   7'h00, 7'h00); // left alt
      8'h29: d = mk(ZONE_MAIN, 3'd4, 4'd3,  KIND_FIXED,  7'h20, 7'h00); // space
      8'h77: d = mk(ZONE_PAD,  3'd0, 4'd0,  KIND_NONE,   7'h00, 7'h00); // num lock
      8'h70: d = mk(ZONE_PAD,  3'd3, 4'd0,  KIND_NUM,    7'h30, 7'h00);
      8'h69: d = mk(ZONE_PAD,  3'd2, 4'd0,  KIND_NUM,    7'h31, 7'h00);
      8'h72: d = mk(ZONE_PAD,  3'd2, 4'd1,  KIND_NUM,    7'h32, 7'h00);
      8'h7A: d = mk(ZONE_PAD,  3'd2, 4'd2,  KIND_NUM,    7'h33, 7'h00);
      8'h6B: d = mk(ZONE_PAD,  3'd1, 4'd0,  KIND_NUM,    7'h34, 7'h00);
      8'h73: d = mk(ZONE_PAD,  3'd1, 4'd1,  KIND_NUM,    7'h35, 7'h00);
      8'h74: d = mk(ZONE_PAD,  3'd1, 4'd2,  KIND_NUM,    7'h36, 7'h00);
      8'h6C: d = mk(ZONE_PAD,  3'd0, 4'd0,  KIND_NUM,    7'h37, 7'h00);
      8'h75: d = mk(ZONE_PAD,  3'd0, 4'd1,  KIND_NUM,    7'h38, 7'h00);
      8'h7D: d = mk(ZONE_PAD,  3'd0, 4'd2,  KIND_NUM,    7'h39, 7'h00);
      8'h71: d = mk(ZONE_PAD,  3'd3, 4'd1,  KIND_NUM,    7'h2E, 7'h00); // keypad dot
      8'h79: d = mk(ZONE_PAD,  3'd3, 4'd2,  KIND_FIXED,  7'h2B, 7'h00); // keypad +
      8'h7B: d = mk(ZONE_PAD,  3'd0, 4'd3,  KIND_FIXED,  7'h2D, 7'h00); // keypad -
      8'h7C: d = mk(ZONE_PAD,  3'd1, 4'd3,  KIND_FIXED,  7'h2A, 7'h00); // keypad *
      8'h7E: d = mk(ZONE_MODS, 3'd0, 4'd2,  KIND_NONE,   7'h00, 7'h00); // scroll lock
      8'h76: d = mk(ZONE_NAV,  3'd0, 4'd4,  KIND_FIXED,  7'h1B, 7'h00); // escape
      default: d = '0;
    endcase
    return d;
  endfunction

  // Key map for codes after the extended prefix
  function automatic keydef_t ext_key(logic [7:0] code);
    keydef_t d;
    d = '0;
    case (code)
      8'h11: d = mk(ZONE_MODS, 3'd4, 4'd4, KIND_NONE,  7'h00, 7'h00); // right alt
      8'h14: d = mk(ZONE_MODS, 3'd4, 4'd7, KIND_NONE,  7'h00, 7'h00); // right ctrl
      8'h1F: d = mk(ZONE_MODS, 3'd4, 4'd1, KIND_NONE,  7'h00, 7'h00); // left win
      8'h27: d = mk(ZONE_MODS, 3'd4, 4'd5, KIND_NONE,  7'h00, 7'h00); // right win
      8'h2F: d = mk(ZONE_MODS, 3'd4, 4'd6, KIND_NONE,  7'h00, 7'h00); // menu
      8'h4A: d = mk(ZONE_PAD,  3'd0, 4'd4, KIND_FIXED, 7'h2F, 7'h00); // keypad /
      8'h5A: d = mk(ZONE_PAD,  3'd3, 4'd4, KIND_FIXED, 7'h0D, 7'h00); // keypad enter
      8'h69: d = mk(ZONE_NAV,  3'd1, 4'd1, KIND_NONE,  7'h00, 7'h00);
      8'h6B: d = mk(ZONE_NAV,  3'd2, 4'd0, KIND_NONE,  7'h00, 7'h00);
      8'h6C: d = mk(ZONE_NAV,  3'd0, 4'd1, KIND_NONE,  7'h00, 7'h00);
      8'h70: d = mk(ZONE_NAV,  3'd0, 4'd0, KIND_NONE,  7'h00, 7'h00);
      8'h71: d = mk(ZONE_NAV,  3'd1, 4'd0, KIND_FIXED, 7'h7F, 7'h00); // delete
      8'h72: d = mk(ZONE_NAV,  3'd2, 4'd1, KIND_NONE,  7'h00, 7'h00);
      8'h74: d = mk(ZONE_NAV,  3'd2, 4'd2, KIND_NONE,  7'h00, 7'h00);
      8'h75: d = mk(ZONE_NAV,  3'd1, 4'd1, KIND_NONE,  7'h00, 7'h00);
      8'h7A: d = mk(ZONE_NAV,  3'd1, 4'd2, KIND_NONE,  7'h00, 7'h00);
      8'h7D: d = mk(ZONE_NAV,  3'd0, 4'd2, KIND_NONE,  7'h00, 7'h00);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[hdl/ps2kbd_keymap.sv]
// Key map lookup and ASCII translation for one scan code.
// Depends on ps2kbd_pkg for the key tables and the modifier struct.
module ps2kbd_keymap
  import ps2kbd_pkg::*;
(
  input  logic [7:0] code,
  input  logic       ext,
  input  key_mod_t   mods,
  output logic       mapped,
  output logic [1:0] zone,
  output logic [2:0] row,
  output logic [3:0] col,
  output logic       ascii_valid,
  output logic [6:0] ascii_code
);

  keydef_t def;

  // Pick the table that the prefix selects
  always_comb begin
    def = ext ? ext_key(code) : main_key(code);
  end

  assign mapped = def.mapped;
  assign zone   = def.zone;
  assign row    = def.row;
  assign col    = def.col;

  // Apply shift, caps, ctrl and num lock rules
  always_comb begin
    ascii_valid = 1'b0;
    ascii_code  = '0;
    case (def.kind)
      KIND_FIXED: begin
        ascii_valid = 1'b1;
        ascii_code  = def.lo;
      end
      KIND_SHIFT: begin
        ascii_valid = 1'b1;
        ascii_code  = mods.shift ? def.hi : def.lo;
      end
      KIND_LETTER: begin
        ascii_valid = 1'b1;
        // ctrl maps a to 1 through z to 26
        if (mods.ctrl) begin
          ascii_code = def.lo - CTRL_OFFSET;
        end else if (mods.shift ^ mods.caps) begin
          ascii_code = def.lo - UPPER_OFFSET;
        end else begin
          ascii_code = def.lo;
        end
      end
      KIND_NUM: begin
        ascii_valid = mods.num;
        ascii_code  = mods.num ? def.lo : 7'd0;
      end
      default: begin
        ascii_valid = 1'b0;
        ascii_code  = '0;
      end
    endcase
  end

endmodule

[hdl/ps2_scancode_to_ascii_decoder_core.sv]
// PS/2 scan code set 2 decoder: takes one keyboard byte per clock cycle and
// gives its key event from a result register in the cycle after acceptance. The
// prefix bytes E0 and F0 are absorbed and give no event. Throughput is one
// byte per cycle while the event side takes words; a word held under stall
// holds the input side too, since the single result register is the only
// buffer. Modifier, lock and prefix flags reset to zero. Depends on
// ps2kbd_pkg and ps2kbd_keymap.
module ps2_scancode_to_ascii_decoder_core
  import ps2kbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // byte input channel
  input  logic       scan_valid,
  output logic       scan_stall,
  input  logic [7:0] scan_byte,
  // key event channel
  output logic       event_valid,
  input  logic       event_stall,
  output logic [7:0] key_code,
  output logic       extended,
  output logic       is_break,
  output logic       mapped,
  output logic [1:0] key_zone,
  output logic [2:0] key_row,
  output logic [3:0] key_col,
  output logic       ascii_valid,
  output logic [6:0] ascii_code,
  output logic [3:0] held_modifiers,
  output logic [2:0] lock_mask,
  output logic       led_update
);

  // Prefix, modifier and lock state
  logic release_pending, release_pending_next;
  logic extended_pending, extended_pending_next;
  logic lshift, lshift_next, rshift, rshift_next;
  logic lctrl, lctrl_next, rctrl, rctrl_next;
  logic lalt, lalt_next, ralt, ralt_next;
  logic lwin, lwin_next, rwin, rwin_next;
  logic caps_on, caps_on_next, num_on, num_on_next, scroll_on, scroll_on_next;
  logic led, event_valid_next;

  logic       take;
  logic       is_prefix;
  logic       down;
  key_mod_t   mods;
  logic       map_hit;
  logic [1:0] map_zone;
  logic [2:0] map_row;
  logic [3:0] map_col;
  logic       map_ascii_valid;
  logic [6:0] map_ascii;

  // Hold input while a stalled word sits in the result register
  assign scan_stall = event_valid && event_stall;
  assign take       = scan_valid && !scan_stall;
  assign is_prefix  = (scan_byte == PREFIX_EXT) || (scan_byte == PREFIX_REL);
  assign down       = !release_pending;

  // Work out the state after this byte
  always_comb begin
    release_pending_next  = release_pending;
    extended_pending_next = extended_pending;
    lshift_next    = lshift;
    rshift_next    = rshift;
    lctrl_next     = lctrl;
    rctrl_next     = rctrl;
    lalt_next      = lalt;
    ralt_next      = ralt;
    lwin_next      = lwin;
    rwin_next      = rwin;
    caps_on_next   = caps_on;
    num_on_next    = num_on;
    scroll_on_next = scroll_on;
    led            = 1'b0;
    if (take) begin
      if (scan_byte == PREFIX_EXT) begin
        extended_pending_next = 1'b1;
      end else if (scan_byte == PREFIX_REL) begin
        release_pending_next = 1'b1;
      end else begin
        release_pending_next  = 1'b0;
        extended_pending_next = 1'b0;
        if (extended_pending) begin
          if (scan_byte == SC_CTRL) begin
            rctrl_next = down;
          end else if (scan_byte == SC_ALT) begin
            ralt_next = down;
          end else if (scan_byte == SC_LWIN) begin
            lwin_next = down;
          end else if (scan_byte == SC_RWIN) begin
            rwin_next = down;
          end
        end else begin
          if (scan_byte == SC_LSHIFT) begin
            lshift_next = down;
          end else if (scan_byte == SC_RSHIFT) begin
            rshift_next = down;
          end else if (scan_byte == SC_CTRL) begin
            lctrl_next = down;
          end else if (scan_byte == SC_ALT) begin
            lalt_next = down;
          end else if (down && scan_byte == SC_CAPS) begin
            caps_on_next = !caps_on;
            led          = 1'b1;
          end else if (down && scan_byte == SC_NUM) begin
            num_on_next = !num_on;
            led         = 1'b1;
          end else if (down && scan_byte == SC_SCROLL) begin
            scroll_on_next = !scroll_on;
            led            = 1'b1;
          end
        end
      end
    end
  end

  assign mods.shift = lshift_next || rshift_next;
  assign mods.ctrl  = lctrl_next || rctrl_next;
  assign mods.caps  = caps_on_next;
  assign mods.num   = num_on_next;

  ps2kbd_keymap u_keymap (
    .code        (scan_byte),
    .ext         (extended_pending),
    .mods        (mods),
    .mapped      (map_hit),
    .zone        (map_zone),
    .row         (map_row),
    .col         (map_col),
    .ascii_valid (map_ascii_valid),
    .ascii_code  (map_ascii)
  );

  // Load on a key byte, drop once the word is taken
  always_comb begin
    event_valid_next = event_valid && event_stall;
    if (take && !is_prefix) begin
      event_valid_next = 1'b1;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      release_pending  <= 1'b0;
      extended_pending <= 1'b0;
      lshift    <= 1'b0;
      rshift    <= 1'b0;
      lctrl     <= 1'b0;
      rctrl     <= 1'b0;
      lalt      <= 1'b0;
      ralt      <= 1'b0;
      lwin      <= 1'b0;
      rwin      <= 1'b0;
      caps_on   <= 1'b0;
      num_on    <= 1'b0;
      scroll_on <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      release_pending  <= release_pending_next;
      extended_pending <= extended_pending_next;
      lshift    <= lshift_next;
      rshift    <= rshift_next;
      lctrl     <= lctrl_next;
      rctrl     <= rctrl_next;
      lalt      <= lalt_next;
      ralt      <= ralt_next;
      lwin      <= lwin_next;
      rwin      <= rwin_next;
      caps_on   <= caps_on_next;
      num_on    <= num_on_next;
      scroll_on <= scroll_on_next;
      event_valid <= event_valid_next;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (take && !is_prefix) begin
      key_code       <= scan_byte;
      extended       <= extended_pending;
      is_break       <= release_pending;
      mapped         <= map_hit;
      key_zone       <= map_zone;
      key_row        <= map_row;
      key_col        <= map_col;
      ascii_valid    <= map_ascii_valid;
      ascii_code     <= map_ascii;
      held_modifiers <= {lwin_next || rwin_next, lalt_next || ralt_next,
                         mods.ctrl, mods.shift};
      lock_mask      <= {caps_on_next, num_on_next, scroll_on_next};
      led_update     <= led;
    end
  end

endmodule

[hdl/ps2kbd_checker.sv]
// Port-level checks for the PS/2 keyboard decoder, bound to its top level.
// Depends on assert_macros.svh and ps2kbd_pkg.
`include "assert_macros.svh"

module ps2kbd_checker
  import ps2kbd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       scan_valid,
  input logic       scan_stall,
  input logic [7:0] scan_byte,
  input logic       event_valid,
  input logic       event_stall,
  input logic [7:0] key_code,
  input logic       extended,
  input logic       is_break,
  input logic       mapped,
  input logic [1:0] key_zone,
  input logic [2:0] key_row,
  input logic [3:0] key_col,
  input logic       ascii_valid,
  input logic [6:0] ascii_code,
  input logic [3:0] held_modifiers,
  input logic [2:0] lock_mask,
  input logic       led_update
);

  logic scan_take;
  logic prefix_byte;
  logic word_held;
  logic plain_press;
  logic blank_word;

  assign scan_take   = scan_valid && !scan_stall;
  assign prefix_byte = (scan_byte == PREFIX_EXT) || (scan_byte == PREFIX_REL);
  assign word_held   = event_valid && event_stall;
  assign plain_press = !is_break && !extended && mapped;
  assign blank_word  = key_zone == ZONE_MAIN && key_row == 3'd0 && key_col == 4'd0 &&
                       !ascii_valid && ascii_code == 7'd0;

  // A stalled word stays put
  `ASSERT_NEXT(a_hold_word, clk, rst, word_held, event_valid && $stable(key_code))
  // A key byte shows up as the next word
  `ASSERT_NEXT(a_key_word, clk, rst, scan_take && !prefix_byte, event_valid && key_code == $past(scan_byte))
  // A prefix byte gives no word
  `ASSERT_NEXT(a_prefix_silent, clk, rst, scan_take && prefix_byte, !event_valid)
  // Only a plain press may request an LED update
  `ASSERT_NOW(a_led_press, clk, rst, event_valid && led_update, plain_press)
  // Unmapped codes carry no position and no character
  `ASSERT_NOW(a_unmapped, clk, rst, event_valid && !mapped, blank_word)

endmodule

bind ps2_scancode_to_ascii_decoder_core ps2kbd_checker u_checker (.*);
